### design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Default and reset values
    localparam int unsigned TICK_COUNTER_WIDTH_DEF = 16;
    localparam int unsigned PHASE_TICKS_W          = 16;
    localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd8;

    // Command codes
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_SACK  = 3'd4,
        CMD_RACK  = 3'd5
    } cmd_t;

    // SDA source for a phase that sets SDA
    typedef enum logic [1:0] {
        SDA_LOW  = 2'd0,
        SDA_HIGH = 2'd1,
        SDA_TX   = 2'd2,
        SDA_ACK  = 2'd3
    } sda_src_t;

    // Action taken on entering a bus phase
    typedef struct packed {
        logic     scl_we;
        logic     scl_val;
        logic     sda_we;
        sda_src_t sda_src;
        logic     shift_tx;
        logic     sample_rx;
        logic     sample_ack;
    } phase_act_t;

    // Input request
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       sda_in;
    } in_item_t;

    // Result
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_ack;
    } out_item_t;

    // Number of phases in each command
    function automatic logic [4:0] phase_count(input cmd_t cmd);
        logic [4:0] n;
        unique case (cmd)
            CMD_START: n = 5'd4;
            CMD_STOP:  n = 5'd3;
            CMD_WRITE: n = 5'd24;
            CMD_READ:  n = 5'd25;
            CMD_SACK:  n = 5'd3;
            CMD_RACK:  n = 5'd4;
            default:   n = 5'd4;
        endcase
        return n;
    endfunction

endpackage

### design/i2cm_phase_decode.sv
// ----------------------------------------------------------------------------
// i2cm_phase_decode
// Decodes command, phase number and bit-slot position into a pin action.
// ----------------------------------------------------------------------------
module i2cm_phase_decode (
    input  i2cm_pkg::cmd_t     cmd,
    input  logic [4:0]         phase,
    input  logic [1:0]         slot,   // phase modulo three
    output i2cm_pkg::phase_act_t act
);

    // Pin action per command
    always_comb
    begin
        act = '{scl_we: 1'b0, scl_val: 1'b0, sda_we: 1'b0,
                sda_src: i2cm_pkg::SDA_HIGH, shift_tx: 1'b0,
                sample_rx: 1'b0, sample_ack: 1'b0};
        unique case (cmd)
            i2cm_pkg::CMD_START:
            begin
                priority if (phase == 5'd0)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_HIGH;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b1;
                end
                else if (phase == 5'd2)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_LOW;
                end
                else
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            i2cm_pkg::CMD_STOP:
            begin
                priority if (phase == 5'd0)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_LOW;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b1;
                end
                else
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_HIGH;
                end
            end
            i2cm_pkg::CMD_WRITE:
            begin
                // data bit, SCL high, SCL low
                priority if (slot == 2'd0)
                begin
                    act.sda_we   = 1'b1;
                    act.sda_src  = i2cm_pkg::SDA_TX;
                    act.shift_tx = 1'b1;
                end
                else if (slot == 2'd1)
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b1;
                end
                else
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            i2cm_pkg::CMD_READ:
            begin
                // release SDA, then SCL high, sample, SCL low per bit
                priority if (phase == 5'd0)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_HIGH;
                end
                else if (slot == 2'd1)
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b1;
                end
                else if (slot == 2'd2)
                begin
                    act.sample_rx = 1'b1;
                end
                else
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            i2cm_pkg::CMD_SACK:
            begin
                priority if (phase == 5'd0)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_ACK;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b1;
                end
                else
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            default:
            begin
                // receive ack
                priority if (phase == 5'd0)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_src = i2cm_pkg::SDA_HIGH;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b1;
                end
                else if (phase == 5'd2)
                begin
                    act.sample_ack = 1'b1;
                end
                else
                begin
                    act.scl_we  = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
        endcase
    end

endmodule

### design/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master engine driven by one timer tick per input request.
// ----------------------------------------------------------------------------
// Each accepted input request is one timer tick and may carry a command.
// The engine takes one tick per clock cycle unless the input is stalled; the
// result for a tick appears in the output register in the cycle after it is
// accepted and is held there while the output is stalled, during which the
// input is stalled as well. Every pin change of a command is a phase lasting
// phase_ticks ticks (0 counts as 1, values above the tick counter range
// saturate). Commands arriving while a command is in progress are dropped. A
// phase_ticks write made while a command runs applies to the current phase at
// once; write it only when no results are outstanding.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
    parameter int unsigned TICK_COUNTER_WIDTH = i2cm_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  i2cm_pkg::in_item_t                  in_data,
    // result output
    output logic                                out_valid,
    input  logic                                out_stall,
    output i2cm_pkg::out_item_t                 out_data,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cm_pkg::PHASE_TICKS_W-1:0]  cfg_data
);

    localparam int unsigned TW = TICK_COUNTER_WIDTH;
    localparam int unsigned PW = i2cm_pkg::PHASE_TICKS_W;
    localparam int unsigned EW = (TW > PW) ? TW : PW;
    localparam logic [EW:0] CNT_MAX = (EW+1)'((65'(1) << TW) - 65'(1));

    // State
    logic [PW-1:0]      phase_ticks_reg;
    i2cm_pkg::cmd_t     active_cmd_reg, active_cmd_next;
    logic               busy_reg, busy_next;
    logic [4:0]         phase_reg, phase_next;
    logic [1:0]         slot_reg, slot_next;
    logic [TW-1:0]      tick_reg, tick_next;
    logic [7:0]         shift_reg, shift_next;
    logic               ack_seen_reg, ack_seen_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic [7:0]         rx_hold_reg, rx_hold_next;
    logic               out_valid_reg;
    i2cm_pkg::out_item_t out_reg, out_next;

    logic               accept;
    logic               done;
    logic               enter;
    i2cm_pkg::cmd_t     dec_cmd;
    logic [4:0]         dec_phase;
    logic [1:0]         dec_slot;
    logic [7:0]         shift_base;
    i2cm_pkg::phase_act_t act;
    logic [EW:0]        eff_ticks;
    logic [EW:0]        tick_sum;
    logic [4:0]         phase_inc;
    logic [1:0]         slot_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Effective phase length
    always_comb
    begin
        logic [EW:0] pt;
        pt = (EW+1)'(phase_ticks_reg);
        priority if (pt == '0)
            eff_ticks = (EW+1)'(1);
        else if (pt > CNT_MAX)
            eff_ticks = CNT_MAX;
        else
            eff_ticks = pt;
    end

    assign tick_sum  = (EW+1)'(tick_reg) + (EW+1)'(1);
    assign phase_inc = phase_reg + 5'd1;
    assign slot_inc  = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;

    i2cm_phase_decode u_decode (
        .cmd   (dec_cmd),
        .phase (dec_phase),
        .slot  (dec_slot),
        .act   (act)
    );

    // Tick sequencing
    always_comb
    begin
        active_cmd_next = active_cmd_reg;
        busy_next       = busy_reg;
        phase_next      = phase_reg;
        slot_next       = slot_reg;
        tick_next       = tick_reg;
        shift_base      = shift_reg;
        rx_hold_next    = rx_hold_reg;
        done            = 1'b0;
        enter           = 1'b0;
        dec_cmd         = active_cmd_reg;
        dec_phase       = phase_inc;
        dec_slot        = slot_inc;
        if (busy_reg)
        begin
            if (tick_sum >= eff_ticks)
            begin
                tick_next = '0;
                if (phase_inc >= i2cm_pkg::phase_count(active_cmd_reg))
                begin
                    busy_next  = 1'b0;
                    phase_next = '0;
                    slot_next  = '0;
                    done       = 1'b1;
                    if (active_cmd_reg == i2cm_pkg::CMD_READ)
                        rx_hold_next = shift_reg;
                end
                else
                begin
                    phase_next = phase_inc;
                    slot_next  = slot_inc;
                    enter      = 1'b1;
                end
            end
            else
            begin
                tick_next = tick_sum[TW-1:0];
            end
        end
        else if (in_data.cmd_valid &&
                 in_data.command <= i2cm_pkg::CMD_RACK)
        begin
            active_cmd_next = i2cm_pkg::cmd_t'(in_data.command);
            busy_next       = 1'b1;
            phase_next      = '0;
            slot_next       = '0;
            tick_next       = '0;
            enter           = 1'b1;
            dec_cmd         = i2cm_pkg::cmd_t'(in_data.command);
            dec_phase       = '0;
            dec_slot        = '0;
            if (in_data.command == i2cm_pkg::CMD_WRITE)
                shift_base = in_data.tx_byte;
            else if (in_data.command == i2cm_pkg::CMD_READ)
                shift_base = '0;
        end
    end

    // Pin and data updates on phase entry
    always_comb
    begin
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        shift_next    = shift_base;
        ack_seen_next = ack_seen_reg;
        if (enter)
        begin
            if (act.scl_we)
                scl_next = act.scl_val;
            if (act.sda_we)
            begin
                unique case (act.sda_src)
                    i2cm_pkg::SDA_LOW:  sda_next = 1'b0;
                    i2cm_pkg::SDA_HIGH: sda_next = 1'b1;
                    i2cm_pkg::SDA_TX:   sda_next = shift_base[7];
                    i2cm_pkg::SDA_ACK:  sda_next = in_data.ack_bit;
                    default:            sda_next = 1'b1;
                endcase
            end
            if (act.shift_tx)
                shift_next = {shift_base[6:0], 1'b0};
            if (act.sample_rx)
                shift_next = {shift_base[6:0], in_data.sda_in};
            if (act.sample_ack)
                ack_seen_next = in_data.sda_in;
        end
    end

    // Result
    always_comb
    begin
        out_next.scl_level   = scl_next;
        out_next.sda_release = sda_next;
        out_next.busy_res    = busy_next;
        out_next.done_res    = done;
        out_next.rx_byte     = rx_hold_next;
        out_next.rx_ack      = ack_seen_next;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
        else if (cfg_valid && cfg_ready)
            phase_ticks_reg <= cfg_data;
    end

    // Engine state, updated per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cmd_reg <= i2cm_pkg::CMD_START;
            busy_reg       <= 1'b0;
            phase_reg      <= '0;
            slot_reg       <= '0;
            tick_reg       <= '0;
            shift_reg      <= '0;
            ack_seen_reg   <= 1'b1;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            rx_hold_reg    <= '0;
        end
        else if (accept)
        begin
            active_cmd_reg <= active_cmd_next;
            busy_reg       <= busy_next;
            phase_reg      <= phase_next;
            slot_reg       <= slot_next;
            tick_reg       <= tick_next;
            shift_reg      <= shift_next;
            ack_seen_reg   <= ack_seen_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

endmodule

### design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input i2cm_pkg::out_item_t out_data
);

    // Every accepted tick produces a result on the next cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted tick produced no result");

    // A taken result with no new tick leaves the output empty
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !(in_valid && !in_stall)) |=> !out_valid)
        else $error("result repeated or invented");

    // Done pulses only as busy falls
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |-> !out_data.busy_res)
        else $error("done reported while still busy");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
